// File: rtl/core/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants of the pulse-distance infrared frame decoder:
// configuration register indexes, reset values, header tolerances and the
// structs that travel between the decoder core and the result emitter.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int DUR_W      = 16;
   localparam int WORD_W     = 64;
   localparam int WORD_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_MARK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SPACE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_MARK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_MARK_TOL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_SPACE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_TOL      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_SPACE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_TOL       = 3'd7;

   // Reset values of the configuration registers, in microseconds.
   localparam logic [DUR_W-1:0] RST_HEADER_MARK   = 16'd9600;
   localparam logic [DUR_W-1:0] RST_HEADER_SPACE  = 16'd5000;
   localparam logic [DUR_W-1:0] RST_DATA_MARK     = 16'd550;
   localparam logic [DUR_W-1:0] RST_DATA_MARK_TOL = 16'd300;
   localparam logic [DUR_W-1:0] RST_ZERO_SPACE    = 16'd600;
   localparam logic [DUR_W-1:0] RST_ZERO_TOL      = 16'd400;
   localparam logic [DUR_W-1:0] RST_ONE_SPACE     = 16'd1500;
   localparam logic [DUR_W-1:0] RST_ONE_TOL       = 16'd500;

   // Fixed exclusive tolerances of the header mark and header space.
   localparam logic [DUR_W-1:0] HDR_MARK_TOL_US  = 16'd2000;
   localparam logic [DUR_W-1:0] HDR_SPACE_TOL_US = 16'd1500;

   typedef struct packed {
      logic [DUR_W-1:0] header_mark_us;
      logic [DUR_W-1:0] header_space_us;
      logic [DUR_W-1:0] data_mark_us;
      logic [DUR_W-1:0] data_mark_tol_us;
      logic [DUR_W-1:0] zero_space_us;
      logic [DUR_W-1:0] zero_space_tol_us;
      logic [DUR_W-1:0] one_space_us;
      logic [DUR_W-1:0] one_space_tol_us;
   } irpd_cfg_type;

   // Handoff of a finished signal from the decoder core to the emitter.
   typedef struct packed {
      logic valid;
      logic ok;
   } irpd_frame_type;

endpackage

// File: rtl/core/irpd_window.sv
// ----------------------------------------------------------------------------
// irpd_window
// Exclusive window test: match is high when |x - v| < d, computed on a
// signed difference so that a tolerance above the nominal value cannot wrap.
// ----------------------------------------------------------------------------
module irpd_window (
   input  logic [irpd_pkg::DUR_W-1:0] x,
   input  logic [irpd_pkg::DUR_W-1:0] v,
   input  logic [irpd_pkg::DUR_W-1:0] d,
   output logic                       match
);
   import irpd_pkg::*;

   logic [DUR_W:0] diff;
   logic [DUR_W:0] mag;

   always_comb begin
      diff  = {1'b0, x} - {1'b0, v};
      mag   = diff[DUR_W] ? ((DUR_W+1)'(0) - diff) : diff;
      match = mag < {1'b0, d};
   end

endmodule

// File: rtl/core/irpd_csr.sv
// ----------------------------------------------------------------------------
// irpd_csr
// Configuration register file: eight 16-bit timing registers written through
// a plain index/data write port, loaded with their defaults at reset.
// ----------------------------------------------------------------------------
module irpd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [irpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [irpd_pkg::DUR_W-1:0]     csr_wdata,
   output irpd_pkg::irpd_cfg_type         cfg
);
   import irpd_pkg::*;

   irpd_cfg_type cfg_ff;
   irpd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_MARK:   cfg_in.header_mark_us    = csr_wdata;
            CSR_HEADER_SPACE:  cfg_in.header_space_us   = csr_wdata;
            CSR_DATA_MARK:     cfg_in.data_mark_us      = csr_wdata;
            CSR_DATA_MARK_TOL: cfg_in.data_mark_tol_us  = csr_wdata;
            CSR_ZERO_SPACE:    cfg_in.zero_space_us     = csr_wdata;
            CSR_ZERO_TOL:      cfg_in.zero_space_tol_us = csr_wdata;
            CSR_ONE_SPACE:     cfg_in.one_space_us      = csr_wdata;
            CSR_ONE_TOL:       cfg_in.one_space_tol_us  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_us    <= RST_HEADER_MARK;
         cfg_ff.header_space_us   <= RST_HEADER_SPACE;
         cfg_ff.data_mark_us      <= RST_DATA_MARK;
         cfg_ff.data_mark_tol_us  <= RST_DATA_MARK_TOL;
         cfg_ff.zero_space_us     <= RST_ZERO_SPACE;
         cfg_ff.zero_space_tol_us <= RST_ZERO_TOL;
         cfg_ff.one_space_us      <= RST_ONE_SPACE;
         cfg_ff.one_space_tol_us  <= RST_ONE_TOL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/irpd_decoder.sv
// ----------------------------------------------------------------------------
// irpd_decoder
// Input register and per-duration decode: header and data window checks,
// position counter, failure flag and the bit store of the current signal.
// ----------------------------------------------------------------------------
module irpd_decoder #(
   parameter int FRAME_BITS = 160
) (
   input  logic                       clock,
   input  logic                       reset,
   input  irpd_pkg::irpd_cfg_type     cfg,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [irpd_pkg::DUR_W-1:0] req_duration,
   input  logic                       req_tlast,
   input  logic                       emit_ready,
   output irpd_pkg::irpd_frame_type   frame,
   output logic [FRAME_BITS-1:0]      frame_bits
);
   import irpd_pkg::*;

   localparam int POS_W = $clog2(2*FRAME_BITS + 4);
   localparam int BIT_W = $clog2(FRAME_BITS);
   localparam logic [POS_W-1:0] NEEDED_POS    = POS_W'(2*FRAME_BITS + 3);
   localparam logic [POS_W-1:0] LAST_USED_POS = POS_W'(2*FRAME_BITS + 1);
   localparam logic [POS_W-1:0] FIRST_DATA    = POS_W'(2);
   localparam logic [POS_W-1:0] FIRST_SPACE   = POS_W'(3);

   logic             full_ff, full_in;
   logic [DUR_W-1:0] dur_ff;
   logic             last_ff;
   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   logic             failed_ff, failed_in;
   logic             mark_ff, mark_in;
   logic [FRAME_BITS-1:0] bits_ff, bits_in;

   logic accept, step;
   logic hm_hit, hs_hit, dm_hit, zero_hit, one_hit;
   logic at_hdr_mark, at_hdr_space, in_data, at_mark, at_space;
   logic fail_now, bit_write;
   logic [POS_W-1:0] bit_off;
   logic [BIT_W-1:0] bit_idx;

   irpd_window u_hdr_mark (
      .x(dur_ff), .v(cfg.header_mark_us), .d(HDR_MARK_TOL_US), .match(hm_hit));
   irpd_window u_hdr_space (
      .x(dur_ff), .v(cfg.header_space_us), .d(HDR_SPACE_TOL_US), .match(hs_hit));
   irpd_window u_data_mark (
      .x(dur_ff), .v(cfg.data_mark_us), .d(cfg.data_mark_tol_us), .match(dm_hit));
   irpd_window u_zero (
      .x(dur_ff), .v(cfg.zero_space_us), .d(cfg.zero_space_tol_us), .match(zero_hit));
   irpd_window u_one (
      .x(dur_ff), .v(cfg.one_space_us), .d(cfg.one_space_tol_us), .match(one_hit));

   // A closing duration waits in the input register until the emitter is free.
   assign step       = full_ff && (!last_ff || emit_ready);
   assign req_tready = !full_ff || step;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      at_hdr_mark  = (pos_ff == '0);
      at_hdr_space = (pos_ff == POS_W'(1));
      in_data      = (pos_ff >= FIRST_DATA) && (pos_ff <= LAST_USED_POS);
      at_mark      = in_data && !pos_ff[0];
      at_space     = in_data && pos_ff[0];

      // The zero window is tested first, so an overlap decodes as zero.
      fail_now = (at_hdr_mark && !hm_hit) || (at_hdr_space && !hs_hit) ||
                 (at_mark && !dm_hit) ||
                 (at_space && mark_ff && !zero_hit && !one_hit);
      mark_in   = at_mark ? dm_hit : mark_ff;
      bit_write = at_space && mark_ff && (zero_hit || one_hit);
      bit_off   = (pos_ff - FIRST_SPACE) >> 1;
      bit_idx   = bit_off[BIT_W-1:0];

      bits_in = bits_ff;
      if (bit_write) begin
         bits_in[bit_idx] = !zero_hit;
      end

      pos_inc   = (pos_ff < NEEDED_POS) ? (pos_ff + POS_W'(1)) : pos_ff;
      failed_in = failed_ff || fail_now;

      full_in = accept ? 1'b1 : (step ? 1'b0 : full_ff);
      pos_in  = pos_ff;
      if (step) begin
         pos_in = last_ff ? '0 : pos_inc;
      end

      frame.valid = step && last_ff;
      frame.ok    = (pos_inc == NEEDED_POS) && !failed_in;
      frame_bits  = bits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff   <= 1'b0;
         pos_ff    <= '0;
         failed_ff <= 1'b0;
         mark_ff   <= 1'b0;
      end else begin
         full_ff <= full_in;
         pos_ff  <= pos_in;
         if (step) begin
            failed_ff <= last_ff ? 1'b0 : failed_in;
            mark_ff   <= last_ff ? 1'b0 : mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dur_ff  <= req_duration;
         last_ff <= req_tlast;
      end
      if (step) begin
         bits_ff <= bits_in;
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= NEEDED_POS)
      else $error("position counter passed its saturation value");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (step && last_ff) |=> (pos_ff == '0) && !failed_ff && !mark_ff)
      else $error("signal state not cleared after a closing duration");

   a_handoff: assert property (@(posedge clock) disable iff (reset)
      frame.valid |-> emit_ready)
      else $error("frame handed to a busy emitter");

endmodule

// File: rtl/core/irpd_emitter.sv
// ----------------------------------------------------------------------------
// irpd_emitter
// Holds a finished frame and sends it as 64-bit words through the result
// register, or a single failure result when the signal did not decode.
// ----------------------------------------------------------------------------
module irpd_emitter #(
   parameter int FRAME_BITS = 160
) (
   input  logic                            clock,
   input  logic                            reset,
   input  irpd_pkg::irpd_frame_type        frame,
   input  logic [FRAME_BITS-1:0]           frame_bits,
   output logic                            emit_ready,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [irpd_pkg::WORD_W-1:0]     rsp_word,
   output logic [irpd_pkg::WORD_IDX_W-1:0] rsp_index,
   output logic                            rsp_status,
   output logic                            rsp_tlast
);
   import irpd_pkg::*;

   localparam int FRAME_WORDS = (FRAME_BITS + 63) / 64;
   localparam int PAD_BITS    = FRAME_WORDS * WORD_W;
   localparam logic [WORD_IDX_W-1:0] LAST_IDX = WORD_IDX_W'(FRAME_WORDS - 1);

   logic                  busy_ff;
   logic                  fail_ff;
   logic [WORD_IDX_W-1:0] idx_ff;
   logic [FRAME_BITS-1:0] bits_ff;

   logic                  valid_ff;
   logic [WORD_W-1:0]     word_ff;
   logic [WORD_IDX_W-1:0] index_ff;
   logic                  status_ff;
   logic                  last_ff;

   logic [PAD_BITS-1:0]   padded;
   logic [WORD_W-1:0]     word_in;
   logic                  word_last;
   logic                  load_out;

   always_comb begin
      padded    = PAD_BITS'(bits_ff);
      word_in   = fail_ff ? '0 : padded[idx_ff*WORD_W +: WORD_W];
      word_last = fail_ff || (idx_ff == LAST_IDX);
      load_out  = busy_ff && (!valid_ff || rsp_tready);
   end

   assign emit_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (frame.valid) begin
            busy_ff <= 1'b1;
         end else if (load_out && word_last) begin
            busy_ff <= 1'b0;
         end
         if (load_out) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame.valid) begin
         fail_ff <= !frame.ok;
         idx_ff  <= '0;
         bits_ff <= frame_bits;
      end else if (load_out) begin
         idx_ff <= idx_ff + WORD_IDX_W'(1);
      end
      if (load_out) begin
         word_ff   <= word_in;
         index_ff  <= fail_ff ? '0 : idx_ff;
         status_ff <= fail_ff;
         last_ff   <= word_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_word   = word_ff;
   assign rsp_index  = index_ff;
   assign rsp_status = status_ff;
   assign rsp_tlast  = last_ff;

   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff) |-> (word_ff == '0) && (index_ff == '0) && last_ff)
      else $error("failure result is not a single zero word");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= LAST_IDX))
      else $error("word counter ran past the last word");

   a_done: assert property (@(posedge clock) disable iff (reset)
      (load_out && word_last) |=> !busy_ff && valid_ff && last_ff)
      else $error("emitter did not finish on the last word");

endmodule

// File: rtl/core/ir_pulse_distance_frame_decoder.sv
// Path: a closing duration goes through the input register, the emitter's frame hold
// and the result register to its first word on rsp; further words follow one per cycle
// unless rsp stalls. Throughput: one duration per cycle; a closing duration is held in
// the input register while the previous frame's words are still in the emitter.
// Reset: synchronous, active high; timing registers return to defaults.
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Decodes pulse-distance infrared frames from a stream of mark and space
// durations and returns the decoded bits as 64-bit words, or a failure result.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder #(
   parameter int FRAME_BITS = 160
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration write port.
   input  logic                           csr_we,
   input  logic [irpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [irpd_pkg::DUR_W-1:0]     csr_wdata,
   // Duration stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // [15:0] duration_us
   input  logic                           req_tlast,   // end_of_signal
   // Result stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,   // [63:0] frame_word
   output logic [2:0]                     rsp_tuser,   // [1:0] word_index, [2] frame_status
   output logic                           rsp_tlast    // last_of_frame
);
   import irpd_pkg::*;

   // The durations alternate mark and space, beginning with the header mark.
   // The header mark and space are checked against fixed tolerances around
   // their configured nominal values. Each of the FRAME_BITS data pairs is a
   // mark that must fit the data-mark window and a space that selects a zero
   // or a one; any miss fails the whole signal. When the closing duration
   // arrives, the core hands a pass or fail verdict together with the bit
   // store to the emitter, which sends the words from its own copy so that
   // the next signal can start decoding at once.

   irpd_cfg_type          cfg;
   irpd_frame_type        frame;
   logic [FRAME_BITS-1:0] frame_bits;
   logic                  emit_ready;
   logic [WORD_IDX_W-1:0] rsp_index;
   logic                  rsp_status;

   irpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irpd_decoder #(
      .FRAME_BITS(FRAME_BITS)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_duration (req_tdata),
      .req_tlast    (req_tlast),
      .emit_ready   (emit_ready),
      .frame        (frame),
      .frame_bits   (frame_bits)
   );

   irpd_emitter #(
      .FRAME_BITS(FRAME_BITS)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .frame_bits (frame_bits),
      .emit_ready (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_tdata),
      .rsp_index  (rsp_index),
      .rsp_status (rsp_status),
      .rsp_tlast  (rsp_tlast)
   );

   // Side band: word index in the low bits, failure flag above it.
   assign rsp_tuser = {rsp_status, rsp_index};

endmodule
